@@ design/dpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types, register codes and the raw depth code table builder.
// ----------------------------------------------------------------------------
package dpc_pkg;

  localparam int RAW_CODES   = 2048;
  localparam int RAW_W       = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 63;
  localparam int CSIZE_H_LSB = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_SCALE  = 3'd1,
    CFG_CSIZE  = 3'd2,
    CFG_ORIGIN = 3'd3,
    CFG_COEF_A = 3'd4,
    CFG_COEF_B = 3'd5,
    CFG_COEF_C = 3'd6,
    CFG_COEF_D = 3'd7
  } cfg_reg_e;

  typedef logic signed [15:0] raw_lut_t [RAW_CODES];

  typedef struct packed {
    logic [1:0]        mode;
    logic [23:0]       scale;
    logic [23:0]       csize;
    logic [62:0]       origin;
    logic [3:0][62:0]  coef;
  } cfg_t;

  typedef struct packed {
    logic [16:0] dmm;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [21:0] px;
    logic [21:0] py;
    logic [21:0] pz;
    logic [12:0] col;
    logic [12:0] row;
    logic        cvalid;
    logic        last;
  } result_t;

  // raw sensor code to mm, rounded half away from zero, saturated
  function automatic logic signed [15:0] code_to_depth_mm(input logic [RAW_W-1:0] code);
    logic signed [63:0] den;
    logic [63:0]        ad;
    logic [63:0]        n2;
    logic [63:0]        d2;
    logic [63:0]        q;
    logic [63:0]        rem;
    logic signed [63:0] qs;
    logic signed [15:0] res;
    res = '0;
    if (code != RAW_W'(RAW_CODES - 1)) begin
      den = 64'sd33309495161 - 64'sd30711016 * $signed({53'd0, code});
      ad  = den[63] ? 64'(-den) : 64'(den);
      n2  = 64'd20920000000000 + ad;
      d2  = ad << 1;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
        rem = {rem[62:0], n2[i]};
        if (rem >= d2) begin
          rem  = rem - d2;
          q[i] = 1'b1;
        end
      end
      qs = den[63] ? -$signed(q) : $signed(q);
      if (qs > 64'sd32767) res = 16'sh7fff;
      else if (qs < -64'sd32768) res = 16'sh8000;
      else res = qs[15:0];
    end
    return res;
  endfunction

  function automatic raw_lut_t build_raw_lut();
    raw_lut_t lut;
    for (int c = 0; c < RAW_CODES; c++) begin
      lut[c] = code_to_depth_mm(RAW_W'(c));
    end
    return lut;
  endfunction

endpackage

@@ design/dpc_ram.sv @@
// ----------------------------------------------------------------------------
// dpc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/dpc_front.sv @@
// ----------------------------------------------------------------------------
// dpc_front
// Input side: raw table fill after reset, depth conversion, short item queue.
// ----------------------------------------------------------------------------
module dpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                raw_en,
  input  logic                in_push,
  output logic                in_full,
  input  logic [15:0]         in_depth_value,
  input  logic signed [15:0]  in_dir_x,
  input  logic signed [15:0]  in_dir_y,
  input  logic signed [15:0]  in_dir_z,
  input  logic                in_pixel_last,
  output dpc_pkg::item_t      q_item,
  output logic                q_valid,
  input  logic                q_take
);

  localparam dpc_pkg::raw_lut_t RawLut = dpc_pkg::build_raw_lut();
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  logic [dpc_pkg::RAW_W:0]   fill_cnt_r;
  logic [dpc_pkg::RAW_W:0]   fill_cnt_nxt;
  logic                      fill_busy;
  logic [15:0]               ram_q;
  logic                      accept;

  logic                      v1_r;
  logic [15:0]               depth1_r;
  logic [15:0]               dx1_r;
  logic [15:0]               dy1_r;
  logic [15:0]               dz1_r;
  logic                      last1_r;
  dpc_pkg::item_t            item1;

  dpc_pkg::item_t            qmem_r [QDepth];
  logic [QAw-1:0]            wp_r;
  logic [QAw-1:0]            rp_r;
  logic [QAw:0]              cnt_r;
  logic [QAw:0]              cnt_nxt;

  assign fill_busy    = !fill_cnt_r[dpc_pkg::RAW_W];
  assign fill_cnt_nxt = fill_busy ? fill_cnt_r + 1'b1 : fill_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
    end else begin
      fill_cnt_r <= fill_cnt_nxt;
    end
  end

  dpc_ram #(.WIDTH(16), .DEPTH(dpc_pkg::RAW_CODES)) u_raw_ram (
    .clk   (clk),
    .we    (fill_busy),
    .waddr (fill_cnt_r[dpc_pkg::RAW_W-1:0]),
    .wdata (RawLut[fill_cnt_r[dpc_pkg::RAW_W-1:0]]),
    .raddr (in_depth_value[dpc_pkg::RAW_W-1:0]),
    .rdata (ram_q)
  );

  // room for the item in flight plus this one
  assign in_full = fill_busy || ((cnt_r + (QAw+1)'(v1_r)) >= (QAw+1)'(QDepth));
  assign accept  = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    depth1_r <= in_depth_value;
    dx1_r    <= in_dir_x;
    dy1_r    <= in_dir_y;
    dz1_r    <= in_dir_z;
    last1_r  <= in_pixel_last;
  end

  always_comb begin
    item1.dmm   = raw_en ? {ram_q[15], ram_q} : {1'b0, depth1_r};
    item1.dir_x = dx1_r;
    item1.dir_y = dy1_r;
    item1.dir_z = dz1_r;
    item1.last  = last1_r;
  end

  assign q_valid = (cnt_r != '0);
  assign q_item  = qmem_r[rp_r];
  assign cnt_nxt = cnt_r + (QAw+1)'(v1_r) - (QAw+1)'(q_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (v1_r) wp_r <= wp_r + 1'b1;
      if (q_take) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      qmem_r[wp_r] <= item1;
    end
  end

endmodule

@@ design/dpc_div.sv @@
// ----------------------------------------------------------------------------
// dpc_div
// Pipelined restoring divider, one quotient bit per stage, high bit first.
// ----------------------------------------------------------------------------
module dpc_div #(
  parameter int NW = 46,
  parameter int QW = 12
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [NW-1:0] rem_r [QW];
  logic [NW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [NW-1:0]    rem_in;
    logic [NW-1:0]    den_in;
    logic [QW-1:0]    quo_in;
    logic [NW+QW-1:0] dsh;
    logic             hit;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quo_in = quo_r[j-1];
    end

    assign dsh = {{QW{1'b0}}, den_in} << (QW-1-j);
    assign hit = ({{QW{1'b0}}, rem_in} >= dsh);

    always_ff @(posedge clk) begin
      rem_r[j] <= hit ? rem_in - dsh[NW-1:0] : rem_in;
      den_r[j] <= den_in;
      quo_r[j] <= quo_in | (QW'(hit) << (QW-1-j));
    end
  end

  assign quo = quo_r[QW-1];

endmodule

@@ design/dpc_back.sv @@
// ----------------------------------------------------------------------------
// dpc_back
// Arithmetic pipeline: point forming, projection, divide, range check,
// result queue with credit toward the front queue.
// ----------------------------------------------------------------------------
module dpc_back #(
  parameter int COLOR_DIM_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dpc_pkg::cfg_t      cfg,
  input  dpc_pkg::item_t     q_item,
  input  logic               q_valid,
  output logic               q_take,
  input  logic               out_pop,
  output logic               out_empty,
  output dpc_pkg::result_t   out_res
);

  localparam int Cdb     = COLOR_DIM_BITS;
  localparam int Lat     = 7 + Cdb;
  localparam int OqDepth = 32;
  localparam int OqAw    = $clog2(OqDepth);
  localparam int Nw      = 46;

  typedef struct packed {
    logic [21:0] px;
    logic [21:0] py;
    logic [21:0] pz;
    logic        last;
    logic        map_en;
    logic        w_zero;
    logic        ovf_u;
    logic        ovf_v;
    logic        neg_u;
    logic        neg_v;
  } side_t;

  function automatic logic signed [20:0] coef_slot(input dpc_pkg::cfg_t c, input int s);
    return $signed(c.coef[s/3][21*(s%3) +: 21]);
  endfunction

  function automatic logic signed [21:0] sat22(input logic signed [33:0] v);
    logic signed [21:0] r;
    if (v > 34'sd2097151) r = 22'sh1fffff;
    else if (v < -34'sd2097152) r = 22'sh200000;
    else r = v[21:0];
    return r;
  endfunction

  logic [Lat-1:0]       vld_r;
  logic [OqAw:0]        outst_r;
  logic [OqAw:0]        outst_nxt;
  logic                 pop;

  // stage 1
  logic signed [16:0]   dmm1_r;
  logic signed [15:0]   dir1_r [3];
  logic                 last1_r;
  // stage 2
  logic signed [41:0]   dsc2_r;
  logic signed [15:0]   dir2_r [3];
  logic                 last2_r;
  // stage 3
  logic signed [57:0]   prod3_r [3];
  logic                 last3_r;
  // stage 4
  logic signed [21:0]   p4_r [3];
  logic                 last4_r;
  // stage 5
  logic signed [42:0]   prod5_r [3][3];
  logic signed [21:0]   p5_r [3];
  logic                 last5_r;
  // stage 6
  logic signed [Nw-1:0] uvw6_r [3];
  logic signed [21:0]   p6_r [3];
  logic                 last6_r;
  // stage 7, divider input
  logic [Nw-1:0]        au7_r;
  logic [Nw-1:0]        av7_r;
  logic [Nw-1:0]        aw7_r;
  side_t                side7_r;
  side_t                side7_nxt;
  side_t                side_r [Cdb];

  logic [Nw-1:0]        au;
  logic [Nw-1:0]        av;
  logic [Nw-1:0]        aw;
  logic [Cdb-1:0]       quo_u;
  logic [Cdb-1:0]       quo_v;

  side_t                sd;
  logic [Cdb-1:0]       wd;
  logic [Cdb-1:0]       ht;
  logic                 in_u;
  logic                 in_v;
  logic                 hit;
  dpc_pkg::result_t     res;

  dpc_pkg::result_t     oq_r [OqDepth];
  logic [OqAw-1:0]      owp_r;
  logic [OqAw-1:0]      orp_r;
  logic [OqAw:0]        ocnt_r;
  logic                 owr;

  // credit: never take more than the result queue can hold
  assign q_take    = q_valid && (outst_r < (OqAw+1)'(OqDepth));
  assign pop       = out_pop && !out_empty;
  assign outst_nxt = outst_r + (OqAw+1)'(q_take) - (OqAw+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      outst_r <= '0;
    end else begin
      vld_r   <= {vld_r[Lat-2:0], q_take};
      outst_r <= outst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dmm1_r    <= q_item.dmm;
    dir1_r[0] <= q_item.dir_x;
    dir1_r[1] <= q_item.dir_y;
    dir1_r[2] <= q_item.dir_z;
    last1_r   <= q_item.last;

    dsc2_r    <= dmm1_r * $signed({1'b0, cfg.scale});
    dir2_r    <= dir1_r;
    last2_r   <= last1_r;

    last3_r   <= last2_r;
    last4_r   <= last3_r;
    p5_r      <= p4_r;
    last5_r   <= last4_r;
    p6_r      <= p5_r;
    last6_r   <= last5_r;
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [20:0] org;
    logic signed [58:0] acc;
    logic signed [33:0] shr;

    assign org = $signed(cfg.origin[21*i +: 21]);
    // add origin at Q30 plus half an lsb, then floor to Q5
    assign acc = prod3_r[i] + (org <<< 25) + 59'sd16777216;
    assign shr = 34'(acc >>> 25);

    always_ff @(posedge clk) begin
      prod3_r[i] <= dsc2_r * dir2_r[i];
      p4_r[i]    <= sat22(shr);
    end

    for (genvar k = 0; k < 3; k++) begin : g_term
      always_ff @(posedge clk) begin
        prod5_r[i][k] <= coef_slot(cfg, 4*i + k) * p4_r[k];
      end
    end

    always_ff @(posedge clk) begin
      uvw6_r[i] <= prod5_r[i][0] + prod5_r[i][1] + prod5_r[i][2]
                 + (coef_slot(cfg, 4*i + 3) <<< 5);
    end
  end

  assign au = uvw6_r[0][Nw-1] ? Nw'(-uvw6_r[0]) : Nw'(uvw6_r[0]);
  assign av = uvw6_r[1][Nw-1] ? Nw'(-uvw6_r[1]) : Nw'(uvw6_r[1]);
  assign aw = uvw6_r[2][Nw-1] ? Nw'(-uvw6_r[2]) : Nw'(uvw6_r[2]);

  always_comb begin
    side7_nxt.px     = p6_r[0];
    side7_nxt.py     = p6_r[1];
    side7_nxt.pz     = p6_r[2];
    side7_nxt.last   = last6_r;
    side7_nxt.map_en = cfg.mode[1];
    side7_nxt.w_zero = (uvw6_r[2] == '0);
    // quotient at or above 2^Cdb can never land inside the image
    side7_nxt.ovf_u  = ({{Cdb{1'b0}}, au} >= {aw, {Cdb{1'b0}}});
    side7_nxt.ovf_v  = ({{Cdb{1'b0}}, av} >= {aw, {Cdb{1'b0}}});
    side7_nxt.neg_u  = (uvw6_r[0][Nw-1] ^ uvw6_r[2][Nw-1]) && (uvw6_r[0] != '0);
    side7_nxt.neg_v  = (uvw6_r[1][Nw-1] ^ uvw6_r[2][Nw-1]) && (uvw6_r[1] != '0);
  end

  always_ff @(posedge clk) begin
    au7_r     <= au;
    av7_r     <= av;
    aw7_r     <= aw;
    side7_r   <= side7_nxt;
    side_r[0] <= side7_r;
    for (int j = 1; j < Cdb; j++) begin
      side_r[j] <= side_r[j-1];
    end
  end

  dpc_div #(.NW(Nw), .QW(Cdb)) u_div_u (
    .clk (clk),
    .num (au7_r),
    .den (aw7_r),
    .quo (quo_u)
  );

  dpc_div #(.NW(Nw), .QW(Cdb)) u_div_v (
    .clk (clk),
    .num (av7_r),
    .den (aw7_r),
    .quo (quo_v)
  );

  assign sd = side_r[Cdb-1];
  assign wd = cfg.csize[Cdb-1:0];
  assign ht = cfg.csize[dpc_pkg::CSIZE_H_LSB +: Cdb];

  always_comb begin
    // a negative quotient that truncates to zero still maps
    in_u = !sd.ovf_u && (!sd.neg_u || (quo_u == '0)) && (quo_u < wd);
    in_v = !sd.ovf_v && (!sd.neg_v || (quo_v == '0)) && (quo_v < ht);
    hit  = sd.map_en && !sd.w_zero && in_u && in_v;
    res.px     = sd.px;
    res.py     = sd.py;
    res.pz     = sd.pz;
    res.col    = hit ? 13'(quo_u) : '1;
    res.row    = hit ? 13'(quo_v) : '1;
    res.cvalid = hit;
    res.last   = sd.last;
  end

  assign owr       = vld_r[Lat-1];
  assign out_empty = (ocnt_r == '0);
  assign out_res   = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (owr) owp_r <= owp_r + 1'b1;
      if (pop) orp_r <= orp_r + 1'b1;
      ocnt_r <= ocnt_r + (OqAw+1)'(owr) - (OqAw+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (owr) begin
      oq_r[owp_r] <= res;
    end
  end

endmodule

@@ design/depth_pixel_to_point_and_color_coord_core.sv @@
// ----------------------------------------------------------------------------
// depth_pixel_to_point_and_color_coord_core
// Depth pixel back-projection to a 3D point and color-camera pixel lookup.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  in_     | in_push / in_full       | depth_value, dir_x/y/z, pixel_last
//  out_    | out_empty / out_pop     | point_x/y/z, color_col/row, color_valid,
//          |                         | frame_end
//  cfg_    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One pixel per clock sustained while the result queue is popped; most of the
// pipeline depth is the one-bit-per-stage divider for column and row.
// After reset the 2048-entry raw code table is filled, one entry a cycle;
// in_full stays high until the fill is done.
// A 32-entry result queue with credit back to a 4-entry front queue lets
// either side stall without losing beats.
// ----------------------------------------------------------------------------
module depth_pixel_to_point_and_color_coord_core #(
  parameter int COLOR_DIM_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [15:0]                       in_depth_value,
  input  logic signed [15:0]                in_dir_x,
  input  logic signed [15:0]                in_dir_y,
  input  logic signed [15:0]                in_dir_z,
  input  logic                              in_pixel_last,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [21:0]                out_point_x,
  output logic signed [21:0]                out_point_y,
  output logic signed [21:0]                out_point_z,
  output logic signed [12:0]                out_color_col,
  output logic signed [12:0]                out_color_row,
  output logic                              out_color_valid,
  output logic                              out_frame_end,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  dpc_pkg::cfg_t    cfg_r;
  dpc_pkg::item_t   q_item;
  logic             q_valid;
  logic             q_take;
  dpc_pkg::result_t res;
  logic             cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= '0;
      cfg_r.scale  <= 24'd65536;
      cfg_r.csize  <= '0;
      cfg_r.origin <= '0;
      cfg_r.coef   <= '0;
    end else if (cfg_wr) begin
      case (dpc_pkg::cfg_reg_e'(cfg_index))
        dpc_pkg::CFG_MODE:   cfg_r.mode    <= cfg_data[1:0];
        dpc_pkg::CFG_SCALE:  cfg_r.scale   <= cfg_data[23:0];
        dpc_pkg::CFG_CSIZE:  cfg_r.csize   <= cfg_data[23:0];
        dpc_pkg::CFG_ORIGIN: cfg_r.origin  <= cfg_data;
        dpc_pkg::CFG_COEF_A: cfg_r.coef[0] <= cfg_data;
        dpc_pkg::CFG_COEF_B: cfg_r.coef[1] <= cfg_data;
        dpc_pkg::CFG_COEF_C: cfg_r.coef[2] <= cfg_data;
        dpc_pkg::CFG_COEF_D: cfg_r.coef[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  dpc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .raw_en         (cfg_r.mode[0]),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_depth_value (in_depth_value),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .in_pixel_last  (in_pixel_last),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .q_take         (q_take)
  );

  dpc_back #(.COLOR_DIM_BITS(COLOR_DIM_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_point_x     = res.px;
  assign out_point_y     = res.py;
  assign out_point_z     = res.pz;
  assign out_color_col   = res.col;
  assign out_color_row   = res.row;
  assign out_color_valid = res.cvalid;
  assign out_frame_end   = res.last;

endmodule

@@ design/dpc_check.sv @@
// ----------------------------------------------------------------------------
// dpc_check
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dpc_check (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [21:0] out_point_x,
  input logic signed [12:0] out_color_col,
  input logic signed [12:0] out_color_row,
  input logic               out_color_valid
);

  // a mapped beat carries a real pixel position
  a_valid_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_color_valid) |-> (!out_color_col[12] && !out_color_row[12]))
    else $error("mapped beat with negative coordinate");

  // an unmapped beat carries -1, -1
  a_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_color_valid) |-> ((out_color_col == '1) && (out_color_row == '1)))
    else $error("unmapped beat without -1 coordinates");

  // a waiting beat stays put until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_point_x)
      && $stable(out_color_col) && $stable(out_color_valid)))
    else $error("waiting beat changed before pop");

endmodule

bind depth_pixel_to_point_and_color_coord_core dpc_check u_dpc_check (.*);

@@ tb/depth_pixel_to_point_and_color_coord_checker.sv @@
// ----------------------------------------------------------------------------
// depth_pixel_to_point_and_color_coord_checker
// Watches the input, result and register channels of the depth back-projection
// core, computes the expected point and color coordinate for each accepted
// pixel and compares every result beat with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module depth_pixel_to_point_and_color_coord_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic                            in_full,
  input  logic [15:0]                     in_depth_value,
  input  logic [15:0]                     in_dir_x,
  input  logic [15:0]                     in_dir_y,
  input  logic [15:0]                     in_dir_z,
  input  logic                            in_pixel_last,
  input  logic                            out_empty,
  input  logic                            out_pop,
  input  logic [21:0]                     out_point_x,
  input  logic [21:0]                     out_point_y,
  input  logic [21:0]                     out_point_z,
  input  logic [12:0]                     out_color_col,
  input  logic [12:0]                     out_color_row,
  input  logic                            out_color_valid,
  input  logic                            out_frame_end,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pending
);

  localparam int DIM_BITS = 12;

  logic [1:0]       mode_r;
  logic [23:0]      scale_r;
  logic [23:0]      csize_r;
  logic [62:0]      origin_r;
  logic [3:0][62:0] coef_r;

  dpc_pkg::result_t expected_points[$];

  function automatic longint raw_code_to_mm(logic [10:0] code);
    longint          den;
    longint          mm;
    longint unsigned mag;
    longint unsigned quo;
    if (code == 11'h7FF) return 0;
    den = 64'sd33309495161 - 64'sd30711016 * $signed({53'd0, code});
    mag = (den < 0) ? -den : den;
    // round half away from zero
    quo = (64'd20920000000000 + mag) / (2 * mag);
    mm = (den < 0) ? -longint'(quo) : longint'(quo);
    if (mm > 32767) mm = 32767;
    if (mm < -32768) mm = -32768;
    return mm;
  endfunction

  function automatic longint coef_at(int slot);
    logic [20:0] f;
    f = coef_r[slot / 3][(slot % 3) * 21 +: 21];
    return $signed(f);
  endfunction

  function automatic dpc_pkg::result_t project_pixel(logic [15:0] depth, logic [15:0] dx,
                                                     logic [15:0] dy, logic [15:0] dz,
                                                     logic last);
    dpc_pkg::result_t r;
    longint  dmm, dsc, acc, o, u, v, w, wd, ht, cx, cy;
    longint  dir [3];
    longint  p   [3];
    logic [20:0] of;
    dmm = mode_r[0] ? raw_code_to_mm(depth[10:0]) : longint'(depth);
    dsc = dmm * longint'(scale_r);
    dir[0] = $signed(dx);
    dir[1] = $signed(dy);
    dir[2] = $signed(dz);
    for (int i = 0; i < 3; i++) begin
      of = origin_r[i * 21 +: 21];
      o = $signed(of);
      acc = dsc * dir[i] + o * (64'sd1 <<< 25);
      p[i] = (acc + (64'sd1 <<< 24)) >>> 25;
      if (p[i] > 2097151) p[i] = 2097151;
      if (p[i] < -2097152) p[i] = -2097152;
    end
    cx = -1;
    cy = -1;
    r.cvalid = 1'b0;
    if (mode_r[1]) begin
      u = coef_at(0) * p[0] + coef_at(1) * p[1] + coef_at(2) * p[2] + coef_at(3) * 32;
      v = coef_at(4) * p[0] + coef_at(5) * p[1] + coef_at(6) * p[2] + coef_at(7) * 32;
      w = coef_at(8) * p[0] + coef_at(9) * p[1] + coef_at(10) * p[2] + coef_at(11) * 32;
      if (w != 0) begin
        wd = csize_r[DIM_BITS-1:0];
        ht = csize_r[dpc_pkg::CSIZE_H_LSB +: DIM_BITS];
        if (u / w >= 0 && u / w < wd && v / w >= 0 && v / w < ht) begin
          cx = u / w;
          cy = v / w;
          r.cvalid = 1'b1;
        end
      end
    end
    r.px = p[0][21:0];
    r.py = p[1][21:0];
    r.pz = p[2][21:0];
    r.col = cx[12:0];
    r.row = cy[12:0];
    r.last = last;
    return r;
  endfunction

  task automatic report(string field, longint exp_v, longint act_v);
    $display("%0t: mismatch on %s, expected %0h, got %0h", $time, field, exp_v, act_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    dpc_pkg::result_t e;
    if (!rst_n) begin
      mode_r   <= 2'd0;
      scale_r  <= 24'd65536;
      csize_r  <= '0;
      origin_r <= '0;
      coef_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (dpc_pkg::cfg_reg_e'(cfg_index))
          dpc_pkg::CFG_MODE:   mode_r   <= cfg_data[1:0];
          dpc_pkg::CFG_SCALE:  scale_r  <= cfg_data[23:0];
          dpc_pkg::CFG_CSIZE:  csize_r  <= cfg_data[23:0];
          dpc_pkg::CFG_ORIGIN: origin_r <= cfg_data;
          dpc_pkg::CFG_COEF_A: coef_r[0] <= cfg_data;
          dpc_pkg::CFG_COEF_B: coef_r[1] <= cfg_data;
          dpc_pkg::CFG_COEF_C: coef_r[2] <= cfg_data;
          dpc_pkg::CFG_COEF_D: coef_r[3] <= cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full)
        expected_points.push_back(project_pixel(in_depth_value, in_dir_x, in_dir_y,
                                                in_dir_z, in_pixel_last));
      if (out_pop && !out_empty) begin
        if (expected_points.size() == 0) begin
          $display("%0t: result beat with nothing expected, got point %0h %0h %0h",
                   $time, out_point_x, out_point_y, out_point_z);
          fail_count++;
        end else begin
          e = expected_points.pop_front();
          if (e.px !== out_point_x) report("point_x", e.px, out_point_x);
          if (e.py !== out_point_y) report("point_y", e.py, out_point_y);
          if (e.pz !== out_point_z) report("point_z", e.pz, out_point_z);
          if (e.col !== out_color_col) report("color_col", e.col, out_color_col);
          if (e.row !== out_color_row) report("color_row", e.row, out_color_row);
          if (e.cvalid !== out_color_valid)
            report("color_valid", e.cvalid, out_color_valid);
          if (e.last !== out_frame_end) report("frame_end", e.last, out_frame_end);
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

@@ tb/depth_pixel_to_point_and_color_coord_core_tb.sv @@
// ----------------------------------------------------------------------------
// depth_pixel_to_point_and_color_coord_core_tb
// Streams depth pixels through the back-projection core under a series of
// register settings, with bursty input and a stalling receiver; the checker
// beside the core predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module depth_pixel_to_point_and_color_coord_core_tb;

  localparam int CYCLE_LIMIT = 400000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_push;
  logic                           in_full;
  logic [15:0]                    in_depth_value;
  logic signed [15:0]             in_dir_x;
  logic signed [15:0]             in_dir_y;
  logic signed [15:0]             in_dir_z;
  logic                           in_pixel_last;
  logic                           out_empty;
  logic                           out_pop;
  logic signed [21:0]             out_point_x;
  logic signed [21:0]             out_point_y;
  logic signed [21:0]             out_point_z;
  logic signed [12:0]             out_color_col;
  logic signed [12:0]             out_color_row;
  logic                           out_color_valid;
  logic                           out_frame_end;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  bit long_hold_req;
  int burst_left;

  depth_pixel_to_point_and_color_coord_core dut (.*);

  depth_pixel_to_point_and_color_coord_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("depth_pixel_to_point_and_color_coord_core_tb NOT OK");
        $finish;
      end
    end
  end

  // the receiver picks a new stall rate every window, plus a long hold on request
  initial begin
    int hold_left, window, rate;
    hold_left = 0;
    window = 0;
    rate = 100;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 300;
      end
      if (window == 0) begin
        window = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: rate = 100;
          1: rate = 80;
          2: rate = 40;
          default: rate = 10;
        endcase
      end
      window--;
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(1, 100) <= rate);
      end
    end
  end

  task automatic push_pixel(logic [15:0] depth, logic [15:0] dx, logic [15:0] dy,
                            logic [15:0] dz, logic last);
    in_push <= 1'b1;
    in_depth_value <= depth;
    in_dir_x <= dx;
    in_dir_y <= dy;
    in_dir_z <= dz;
    in_pixel_last <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic write_reg(dpc_pkg::cfg_reg_e idx, logic [62:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // stop sending and let every expected result come back
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [62:0] pack3(logic [20:0] lo, logic [20:0] mid,
                                        logic [20:0] hi);
    return {hi, mid, lo};
  endfunction

  function automatic logic [20:0] near(int center, int spread);
    return 21'(center + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // kind 0 plausible camera, 1 extreme values, 2 zero projection, 3 anything
  task automatic apply_settings(int kind);
    logic [62:0] r [8];
    case (kind)
      0: begin
        r[dpc_pkg::CFG_MODE] = 63'($urandom_range(0, 3) | 2);
        r[dpc_pkg::CFG_SCALE] = 63'($urandom_range(16384, 131072));
        r[dpc_pkg::CFG_CSIZE] = {12'($urandom_range(200, 4095)),
                                 12'($urandom_range(200, 4095))};
        r[dpc_pkg::CFG_ORIGIN] = pack3(near(0, 4000), near(0, 4000), near(0, 4000));
        r[dpc_pkg::CFG_COEF_A] = pack3(near(1024, 200), near(0, 50), near(0, 50));
        r[dpc_pkg::CFG_COEF_B] = pack3(21'($urandom_range(0, 1 << 19)), near(0, 50),
                                       near(1024, 200));
        r[dpc_pkg::CFG_COEF_C] = pack3(near(0, 50), 21'($urandom_range(0, 1 << 19)),
                                       near(0, 4));
        r[dpc_pkg::CFG_COEF_D] = pack3(near(0, 4), near(0, 8),
                                       21'($urandom_range(512, 8192)));
      end
      1: begin
        r[dpc_pkg::CFG_MODE] = 2'd3;
        r[dpc_pkg::CFG_SCALE] = 24'hFFFFFF;
        r[dpc_pkg::CFG_CSIZE] = 24'hFFFFFF;
        r[dpc_pkg::CFG_ORIGIN] = {63{1'b1}};
        r[dpc_pkg::CFG_COEF_A] = pack3(21'h0FFFFF, 21'h100000, 21'h0FFFFF);
        r[dpc_pkg::CFG_COEF_B] = pack3(21'h100000, 21'h0FFFFF, 21'h100000);
        r[dpc_pkg::CFG_COEF_C] = pack3(21'h0FFFFF, 21'h100000, 21'h0FFFFF);
        r[dpc_pkg::CFG_COEF_D] = pack3(21'h100000, 21'h0FFFFF, 21'h100000);
      end
      2: begin
        r[dpc_pkg::CFG_MODE] = 2'd2;
        r[dpc_pkg::CFG_SCALE] = 24'd0;
        r[dpc_pkg::CFG_CSIZE] = 24'd0;
        r[dpc_pkg::CFG_ORIGIN] = pack3(21'h0FFFFF, 21'h100000, 21'h000001);
        r[dpc_pkg::CFG_COEF_A] = '0;
        r[dpc_pkg::CFG_COEF_B] = '0;
        r[dpc_pkg::CFG_COEF_C] = '0;
        r[dpc_pkg::CFG_COEF_D] = '0;
      end
      default: begin
        for (int i = 0; i < 8; i++)
          r[i] = 63'({$urandom, $urandom});
      end
    endcase
    write_reg(dpc_pkg::CFG_MODE, r[dpc_pkg::CFG_MODE]);
    write_reg(dpc_pkg::CFG_SCALE, r[dpc_pkg::CFG_SCALE]);
    write_reg(dpc_pkg::CFG_CSIZE, r[dpc_pkg::CFG_CSIZE]);
    write_reg(dpc_pkg::CFG_ORIGIN, r[dpc_pkg::CFG_ORIGIN]);
    write_reg(dpc_pkg::CFG_COEF_A, r[dpc_pkg::CFG_COEF_A]);
    write_reg(dpc_pkg::CFG_COEF_B, r[dpc_pkg::CFG_COEF_B]);
    write_reg(dpc_pkg::CFG_COEF_C, r[dpc_pkg::CFG_COEF_C]);
    write_reg(dpc_pkg::CFG_COEF_D, r[dpc_pkg::CFG_COEF_D]);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_random(bit no_gaps);
    logic [15:0] depth, d [3];
    int g;
    case ($urandom_range(0, 3))
      0: depth = 16'($urandom);
      1: depth = 16'($urandom_range(0, 4000));
      2: depth = {5'($urandom), 11'($urandom_range(2040, 2047))};
      default: depth = 16'($urandom_range(0, 2047));
    endcase
    for (int i = 0; i < 3; i++)
      d[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 60);
        g = $urandom_range(0, 6);
        if (g > 0) begin
          in_push <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
      burst_left--;
    end
    push_pixel(depth, d[0], d[1], d[2], $urandom_range(0, 15) == 0);
  endtask

  initial begin
    in_push = 1'b0;
    in_depth_value = '0;
    in_dir_x = '0;
    in_dir_y = '0;
    in_dir_z = '0;
    in_pixel_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    long_hold_req = 1'b0;
    burst_left = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: plain depth, mapping off
    push_pixel(16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    push_pixel(16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh4000, 1'b1);
    push_pixel(16'd1000, 16'sh8000, 16'sh7FFF, 16'shC000, 1'b0);
    drain();

    // raw codes at both ends and the dead code, with high bits set
    apply_settings(1);
    push_pixel(16'd0, 16'sh4000, 16'sh4000, 16'sh4000, 1'b0);
    push_pixel(16'd2046, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    push_pixel(16'd2047, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    push_pixel(16'hFFFF, 16'sh0001, 16'shFFFF, 16'sh0000, 1'b1);
    push_pixel(16'hF800, 16'sh7FFF, 16'sh0000, 16'sh8000, 1'b0);
    push_pixel(16'd1084, 16'sh4000, 16'shC000, 16'sh4000, 1'b0);
    push_pixel(16'd1085, 16'sh4000, 16'shC000, 16'sh4000, 1'b1);
    drain();

    // zero w, zero image size
    apply_settings(2);
    push_pixel(16'd500, 16'sh4000, 16'sh4000, 16'sh4000, 1'b0);
    push_pixel(16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
    drain();

    // plausible camera, in and out of the image
    apply_settings(0);
    push_pixel(16'd800, 16'sh0000, 16'sh0000, 16'sh4000, 1'b0);
    push_pixel(16'd1500, 16'sh1000, 16'shF000, 16'sh4000, 1'b0);
    push_pixel(16'd1200, 16'sh8000, 16'sh8000, 16'sh4000, 1'b0);
    push_pixel(16'd3000, 16'sh7FFF, 16'sh7FFF, 16'shC000, 1'b1);
    drain();

    // receiver holds off long while the sender keeps going
    long_hold_req = 1'b1;
    repeat (120) push_random(1'b1);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 7)
        3: apply_settings(1);
        5: apply_settings(2);
        6: apply_settings(3);
        default: apply_settings(0);
      endcase
      repeat (110) push_random(1'b0);
      drain();
    end

    if (fail_count == 0) begin
      $display("depth_pixel_to_point_and_color_coord_core_tb OK");
    end else begin
      $display("depth_pixel_to_point_and_color_coord_core_tb NOT OK");
    end
    $finish;
  end

endmodule
